// ----- hdl/ssdp_header_extractor_macros.svh -----
// Assertion macros shared by the SSDP header extractor RTL.
`ifndef SSDP_HEADER_EXTRACTOR_MACROS_SVH
`define SSDP_HEADER_EXTRACTOR_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SSDP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SSDP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ssdp_pkg.sv -----
// Types, constants and match tables for the SSDP header extractor.
package ssdp_pkg;

   localparam int VALUE_BUF = 1024;
   localparam int NUM_HDR   = 6;
   localparam int NUM_PFX   = 3;
   localparam int NUM_EV    = 3;

   localparam logic [9:0] VALUE_MAX = 10'(VALUE_BUF - 1);
   localparam logic [5:0] HDR_ALL   = 6'h3F;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam logic [7:0] PFX_TEXT [NUM_PFX][9] = '{
      '{"M", "-", "S", "E", "A", "R", "C", "H", " "},
      '{"N", "O", "T", "I", "F", "Y", " ", "*", " "},
      '{"H", "T", "T", "P", "/", "1", ".", 8'h00, 8'h00}
   };
   localparam logic [3:0] PFX_LEN [NUM_PFX] = '{4'd9, 4'd9, 4'd7};

   localparam logic [7:0] HDR_TEXT [NUM_HDR][10] = '{
      '{"S", "E", "R", "V", "E", "R", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"U", "S", "E", "R", "-", "A", "G", "E", "N", "T"},
      '{"S", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"N", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"U", "S", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"L", "O", "C", "A", "T", "I", "O", "N", 8'h00, 8'h00}
   };
   localparam logic [3:0] HDR_LEN [NUM_HDR] = '{4'd6, 4'd10, 4'd2, 4'd2, 4'd3, 4'd8};

   // Evidence patterns for HTTP responses, searched over the whole packet.
   localparam logic [7:0] EV_TEXT [NUM_EV][6] = '{
      '{8'h0D, 8'h0A, "S", "T", ":", 8'h00},
      '{8'h0D, 8'h0A, "U", "S", "N", ":"},
      '{"U", "P", "n", "P", 8'h00, 8'h00}
   };
   localparam logic [2:0] EV_LEN [NUM_EV] = '{3'd5, 3'd6, 3'd4};

   typedef enum logic [2:0] {
      PH_START, PH_LSTART, PH_NAME, PH_VSKIP, PH_VALUE, PH_REST, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      REC_VALUE_BYTE, REC_VALUE_END, REC_VERDICT
   } rec_kind_type;

   typedef enum logic [1:0] {
      START_NONE, START_MSEARCH, START_NOTIFY, START_HTTP
   } start_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
      logic       session_known;
   } req_item_type;

   typedef struct packed {
      rec_kind_type   kind;
      logic [2:0]     header_kind;
      logic [7:0]     value_byte;
      logic [9:0]     value_length;
      start_kind_type start_kind;
      logic           accepted;
   } rsp_rec_type;

   typedef struct packed {
      logic [1:0]            count;
      rsp_rec_type [2:0]     recs;
   } rsp_set_type;

endpackage

// ----- hdl/ssdp_if.sv -----
// Request and response channel interfaces of the SSDP header extractor.
interface ssdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_end;
   logic       session_known;

   modport source (output valid, data_byte, packet_end, session_known, input ready);
   modport sink   (input valid, data_byte, packet_end, session_known, output ready);
endinterface

interface ssdp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] record_kind;
   logic [2:0] header_kind;
   logic [7:0] value_byte;
   logic [9:0] value_length;
   logic [1:0] start_kind;
   logic       accepted;
   logic       last_of_run;

   modport source (output valid, record_kind, header_kind, value_byte, value_length,
                   start_kind, accepted, last_of_run, input ready);
   modport sink   (input valid, record_kind, header_kind, value_byte, value_length,
                   start_kind, accepted, last_of_run, output ready);
endinterface

// ----- hdl/ssdp_parser.sv -----
// Per-packet parse state and the result set produced by one payload byte.
`include "ssdp_header_extractor_macros.svh"

module ssdp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 proc_en,
   input  ssdp_pkg::req_item_type item,
   input  logic                 csr_wr_en,
   input  logic [5:0]           csr_wr_data,
   output ssdp_pkg::rsp_set_type rsp_set
);
   import ssdp_pkg::*;

   logic [5:0] hen_ff;

   phase_type  phase_ff, phase_in;
   logic [2:0] pfx_ff, pfx_in;
   logic [3:0] bc_ff, bc_in;
   logic [5:0] cand_ff, cand_in;
   logic [3:0] nlen_ff, nlen_in;
   logic [2:0] hdr_ff, hdr_in;
   logic [9:0] vcnt_ff, vcnt_in;
   logic [9:0] tcnt_ff, tcnt_in;
   logic       nonempty_ff, nonempty_in;
   logic [2:0] ev_pos_ff [NUM_EV];
   logic [2:0] ev_pos_in [NUM_EV];
   logic       ev_found_ff, ev_found_in;

   logic [7:0] b, u;
   logic [5:0] cand_cur, cand_upd;
   logic [3:0] len_cur, len_upd;
   logic       col_hit;
   logic [2:0] col_hdr;
   logic [2:0] np;
   logic       a_v, end_v;
   rsp_rec_type rec_a, rec_end, rec_verdict;
   start_kind_type sk;
   logic [1:0] cnt;

   always_comb begin
      b  = item.data_byte;
      u  = (b inside {[8'h61:8'h7A]}) ? (b - 8'h20) : b;

      phase_in    = phase_ff;
      pfx_in      = pfx_ff;
      bc_in       = bc_ff;
      cand_in     = cand_ff;
      nlen_in     = nlen_ff;
      hdr_in      = hdr_ff;
      vcnt_in     = vcnt_ff;
      tcnt_in     = tcnt_ff;
      nonempty_in = nonempty_ff;
      ev_found_in = ev_found_ff;
      a_v         = 1'b0;
      end_v       = 1'b0;
      rec_a       = '0;
      rec_end     = '0;
      rec_verdict = '0;
      sk          = START_NONE;
      np          = '0;

      // start-line prefix check
      if (bc_ff < 4'd9) begin
         for (int k = 0; k < NUM_PFX; k++) begin
            if (bc_ff < PFX_LEN[k] && b != PFX_TEXT[k][bc_ff]) begin
               pfx_in[k] = 1'b0;
            end
         end
         bc_in = bc_ff + 4'd1;
      end

      for (int e = 0; e < NUM_EV; e++) begin
         if (ev_pos_ff[e] < EV_LEN[e] && b == EV_TEXT[e][ev_pos_ff[e]]) begin
            np = ev_pos_ff[e] + 3'd1;
         end else begin
            np = (b == EV_TEXT[e][0]) ? 3'd1 : 3'd0;
         end
         if (np >= EV_LEN[e]) begin
            ev_found_in = 1'b1;
            np          = 3'd0;
         end
         ev_pos_in[e] = np;
      end

      // header name matching
      cand_cur = (phase_ff == PH_LSTART) ? HDR_ALL : cand_ff;
      len_cur  = (phase_ff == PH_LSTART) ? 4'd0 : nlen_ff;
      cand_upd = cand_cur;
      for (int k = 0; k < NUM_HDR; k++) begin
         if (len_cur >= HDR_LEN[k] || u != HDR_TEXT[k][len_cur]) begin
            cand_upd[k] = 1'b0;
         end
      end
      len_upd = (len_cur < 4'd11) ? (len_cur + 4'd1) : len_cur;

      col_hit = 1'b0;
      col_hdr = '0;
      for (int k = NUM_HDR - 1; k >= 0; k--) begin
         if (cand_cur[k] && HDR_LEN[k] == len_cur && hen_ff[k]) begin
            col_hit = 1'b1;
            col_hdr = 3'(k);
         end
      end

      case (phase_ff)
         PH_START, PH_REST: begin
            if (b == CHAR_LF) begin
               phase_in    = PH_LSTART;
               nonempty_in = 1'b0;
            end
         end
         PH_LSTART, PH_NAME: begin
            if (b == CHAR_LF) begin
               phase_in    = (phase_ff == PH_NAME && nonempty_ff) ? PH_LSTART : PH_DONE;
               nonempty_in = (phase_ff == PH_NAME) ? 1'b0 : nonempty_ff;
            end else begin
               nonempty_in = (phase_ff == PH_LSTART) ? (b != CHAR_CR) : 1'b1;
               if (b == CHAR_COLON) begin
                  cand_in = cand_cur;
                  nlen_in = len_cur;
                  if (col_hit) begin
                     phase_in = PH_VSKIP;
                     hdr_in   = col_hdr;
                     vcnt_in  = '0;
                     tcnt_in  = '0;
                  end else begin
                     phase_in = PH_REST;
                  end
               end else begin
                  phase_in = PH_NAME;
                  cand_in  = cand_upd;
                  nlen_in  = len_upd;
               end
            end
         end
         PH_VSKIP, PH_VALUE: begin
            if (b == CHAR_LF || b == CHAR_CR) begin
               a_v                = 1'b1;
               rec_a.kind         = REC_VALUE_END;
               rec_a.header_kind  = hdr_ff;
               rec_a.value_length = tcnt_ff;
               phase_in           = (b == CHAR_LF) ? PH_LSTART : PH_REST;
               nonempty_in        = 1'b0;
            end else if (!(phase_ff == PH_VSKIP && (b == CHAR_SP || b == CHAR_TAB))) begin
               phase_in = PH_VALUE;
               if (vcnt_ff < VALUE_MAX) begin
                  vcnt_in = vcnt_ff + 10'd1;
                  if (b != CHAR_SP && b != CHAR_TAB) begin
                     tcnt_in = vcnt_in;
                  end
                  a_v               = 1'b1;
                  rec_a.kind        = REC_VALUE_BYTE;
                  rec_a.header_kind = hdr_ff;
                  rec_a.value_byte  = b;
               end
            end
         end
         default: begin
         end
      endcase

      // packet end: close an open value, then the verdict
      if (phase_in inside {PH_VSKIP, PH_VALUE}) begin
         end_v = item.packet_end;
      end
      rec_end.kind         = REC_VALUE_END;
      rec_end.header_kind  = hdr_in;
      rec_end.value_length = tcnt_in;

      if (pfx_in[0] && bc_in >= 4'd9) begin
         sk = START_MSEARCH;
      end else if (pfx_in[1] && bc_in >= 4'd9) begin
         sk = START_NOTIFY;
      end else if (pfx_in[2] && bc_in >= 4'd8) begin
         sk = START_HTTP;
      end
      rec_verdict.kind       = REC_VERDICT;
      rec_verdict.start_kind = sk;
      rec_verdict.accepted   = (sk == START_MSEARCH) || (sk == START_NOTIFY) ||
                               (sk == START_HTTP && (item.session_known || ev_found_in));

      rsp_set = '0;
      cnt     = 2'd0;
      if (a_v) begin
         rsp_set.recs[cnt] = rec_a;
         cnt               = cnt + 2'd1;
      end
      if (end_v) begin
         rsp_set.recs[cnt] = rec_end;
         cnt               = cnt + 2'd1;
      end
      if (item.packet_end) begin
         rsp_set.recs[cnt] = rec_verdict;
         cnt               = cnt + 2'd1;
      end
      rsp_set.count = cnt;

      if (item.packet_end) begin
         phase_in    = PH_START;
         pfx_in      = '1;
         bc_in       = '0;
         cand_in     = HDR_ALL;
         nlen_in     = '0;
         hdr_in      = '0;
         vcnt_in     = '0;
         tcnt_in     = '0;
         nonempty_in = 1'b0;
         ev_found_in = 1'b0;
         for (int e = 0; e < NUM_EV; e++) begin
            ev_pos_in[e] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hen_ff      <= HDR_ALL;
         phase_ff    <= PH_START;
         pfx_ff      <= '1;
         bc_ff       <= '0;
         cand_ff     <= HDR_ALL;
         nlen_ff     <= '0;
         hdr_ff      <= '0;
         vcnt_ff     <= '0;
         tcnt_ff     <= '0;
         nonempty_ff <= 1'b0;
         ev_found_ff <= 1'b0;
         for (int e = 0; e < NUM_EV; e++) begin
            ev_pos_ff[e] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            hen_ff <= csr_wr_data;
         end
         if (proc_en) begin
            phase_ff    <= phase_in;
            pfx_ff      <= pfx_in;
            bc_ff       <= bc_in;
            cand_ff     <= cand_in;
            nlen_ff     <= nlen_in;
            hdr_ff      <= hdr_in;
            vcnt_ff     <= vcnt_in;
            tcnt_ff     <= tcnt_in;
            nonempty_ff <= nonempty_in;
            ev_found_ff <= ev_found_in;
            for (int e = 0; e < NUM_EV; e++) begin
               ev_pos_ff[e] <= ev_pos_in[e];
            end
         end
      end
   end

   `SSDP_ASSERT_NEXT(a_packet_clears, clock, reset, proc_en && item.packet_end, phase_ff == PH_START && bc_ff == 4'd0 && !ev_found_ff, "parse state not cleared after packet end")
   `SSDP_ASSERT_ALWAYS(a_trim_le_count, clock, reset, tcnt_ff <= vcnt_ff, "trimmed length exceeds value length")
   `SSDP_ASSERT_ALWAYS(a_counts_saturate, clock, reset, bc_ff <= 4'd9 && nlen_ff <= 4'd11, "byte or name counter past saturation")

endmodule

// ----- hdl/ssdp_header_extractor.sv -----
// SSDP header extractor: one payload byte in per cycle while results drain as fast; up to three
// result records per byte, delivered one per cycle from a result register while rsp_chan.ready
// is high. A byte is taken into an input register and parsed into the result register once that
// register is free; its first record then shows on the response channel. A byte that yields two
// or three records holds the result register until its last record is taken. The user must write
// the header_enable register via csr_wr_en/csr_wr_data while no request is in flight; the block does not enforce it.
`include "ssdp_header_extractor_macros.svh"

module ssdp_header_extractor (
   input  logic       clock,
   input  logic       reset,
   ssdp_req_if.sink   req_chan,
   ssdp_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);
   import ssdp_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         res_valid_ff, res_valid_in;
   rsp_set_type  res_set_ff, res_set_in;
   logic [1:0]   res_idx_ff, res_idx_in;

   rsp_set_type  res_set;
   rsp_rec_type  cur_rec;
   logic         rsp_last;
   logic         res_free;
   logic         proc;
   logic         req_take;

   ssdp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .proc_en     (proc),
      .item        (in_item_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_set     (res_set)
   );

   always_comb begin
      rsp_last = (res_idx_ff == (res_set_ff.count - 2'd1));
      res_free = !res_valid_ff || (rsp_chan.ready && rsp_last);
      proc     = in_valid_ff && res_free;
      req_chan.ready = !in_valid_ff || proc;
      req_take = req_chan.valid && req_chan.ready;

      in_valid_in = req_take ? 1'b1 : (proc ? 1'b0 : in_valid_ff);
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_item_in.data_byte     = req_chan.data_byte;
         in_item_in.packet_end    = req_chan.packet_end;
         in_item_in.session_known = req_chan.session_known;
      end

      res_valid_in = res_valid_ff;
      res_set_in   = res_set_ff;
      res_idx_in   = res_idx_ff;
      if (proc) begin
         res_valid_in = (res_set.count != 2'd0);
         res_set_in   = res_set;
         res_idx_in   = 2'd0;
      end else if (res_valid_ff && rsp_chan.ready) begin
         if (rsp_last) begin
            res_valid_in = 1'b0;
         end else begin
            res_idx_in = res_idx_ff + 2'd1;
         end
      end

      cur_rec = res_set_ff.recs[res_idx_ff];
   end

   assign rsp_chan.valid        = res_valid_ff;
   assign rsp_chan.record_kind  = cur_rec.kind;
   assign rsp_chan.header_kind  = cur_rec.header_kind;
   assign rsp_chan.value_byte   = cur_rec.value_byte;
   assign rsp_chan.value_length = cur_rec.value_length;
   assign rsp_chan.start_kind   = cur_rec.start_kind;
   assign rsp_chan.accepted     = cur_rec.accepted;
   assign rsp_chan.last_of_run  = rsp_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         res_idx_ff   <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         res_valid_ff <= res_valid_in;
         res_idx_ff   <= res_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      res_set_ff <= res_set_in;
   end

   `SSDP_ASSERT_ALWAYS(a_idx_in_range, clock, reset, !res_valid_ff || (res_idx_ff < res_set_ff.count), "record index beyond result count")
   `SSDP_ASSERT_IMPLY(a_verdict_last, clock, reset, rsp_chan.valid && rsp_chan.record_kind == REC_VERDICT, rsp_chan.last_of_run, "verdict not last of run")
   `SSDP_ASSERT_NEXT(a_result_loads, clock, reset, proc && res_set.count != 2'd0, res_valid_ff && res_idx_ff == 2'd0, "result register not loaded from request")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the SSDP header extractor: packet stimulus, byte-level predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssdp_pkg::*;

   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_SP    = 8'h20;
   localparam logic [7:0] ASCII_TAB   = 8'h09;
   localparam logic [7:0] ASCII_COLON = 8'h3A;
   localparam int VALUE_CAP   = 1023;
   localparam int PHASE_BYTES = 36;
   localparam int SETTLE      = 8;

   typedef struct packed {
      rec_kind_type   kind;
      logic [2:0]     hdr;
      logic [7:0]     vbyte;
      logic [9:0]     vlen;
      start_kind_type sk;
      logic           acc;
      logic           last;
   } out_rec_type;

   typedef struct {
      string          text;
      bit             known;
      bit             typed;
      start_kind_type sk;
      bit             acc;
   } probe_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic [5:0] csr_wr_data;
   logic       rsp_take = 1'b0;

   ssdp_req_if req ();
   ssdp_rsp_if rsp ();

   assign rsp.ready = rsp_take;

   ssdp_header_extractor u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   string prefix_txt [3] = '{"M-SEARCH ", "NOTIFY * ", "HTTP/1."};
   string header_txt [6] = '{"SERVER", "USER-AGENT", "ST", "NT", "USN", "LOCATION"};
   string start_txt  [3] = '{"M-SEARCH * ", "NOTIFY * ", "HTTP/1.1 "};

   probe_type probes [12] = '{
      '{"X",         1'b1, 1'b1, START_NONE,    1'b0},
      '{"HTTP/1.",   1'b1, 1'b1, START_NONE,    1'b0},
      '{"HTTP/1.1",  1'b0, 1'b1, START_HTTP,    1'b0},
      '{"HTTP/1.1",  1'b1, 1'b1, START_HTTP,    1'b1},
      '{"M-SEARCH ", 1'b0, 1'b1, START_MSEARCH, 1'b1},
      '{"NOTIFY * ", 1'b0, 1'b1, START_NOTIFY,  1'b1},
      '{"m-search ", 1'b1, 1'b1, START_NONE,    1'b0},
      '{"HTTP/1.1\015\nST:x\015\n", 1'b0, 1'b0, START_NONE, 1'b0},
      '{"HTTP/1.1\nusn:\t a b \t\015\n\015\nLOCATION:zz", 1'b0, 1'b0, START_NONE, 1'b0},
      '{"NOTIFY * \nSERVER:ab\015cd\nUser-Agent:q", 1'b0, 1'b0, START_NONE, 1'b0},
      '{"NOTIFY * \nNT:\nST\n:z\nLOCATIONLOCATION:v\nX-UPnP:1\n\nST:gone", 1'b1, 1'b0,
        START_NONE, 1'b0},
      '{"HTTP/1.0 UPnP\n\377\200:\177\n", 1'b0, 1'b0, START_NONE, 1'b0}
   };

   out_rec_type records_due [$];
   logic [7:0]  pkt_bytes [$];
   int          errors = 0;
   bit          steady = 1'b0;

   // parser state mirror
   logic [5:0] hdr_en;
   phase_type  phase;
   logic [2:0] pfx_cand;
   logic [3:0] byte_cnt;
   logic [5:0] name_cand;
   logic [3:0] name_len;
   logic [2:0] cur_hdr;
   logic [9:0] val_cnt;
   logic [9:0] trim_cnt;
   logic       line_nonempty;
   logic [2:0] st_pos;
   logic [2:0] usn_pos;
   logic [2:0] upnp_pos;
   logic       ev_found;

   function automatic void packet_clear();
      phase         = PH_START;
      pfx_cand      = 3'h7;
      byte_cnt      = '0;
      name_cand     = 6'h3F;
      name_len      = '0;
      cur_hdr       = '0;
      val_cnt       = '0;
      trim_cnt      = '0;
      line_nonempty = 1'b0;
      st_pos        = '0;
      usn_pos       = '0;
      upnp_pos      = '0;
      ev_found      = 1'b0;
   endfunction

   function automatic out_rec_type make_rec(rec_kind_type kind, logic [2:0] hdr,
                                            logic [7:0] vbyte, logic [9:0] vlen,
                                            start_kind_type sk, logic acc);
      out_rec_type r;
      r.kind  = kind;
      r.hdr   = hdr;
      r.vbyte = vbyte;
      r.vlen  = vlen;
      r.sk    = sk;
      r.acc   = acc;
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic logic [2:0] ev_step(logic [2:0] pos, logic [7:0] b, string pat);
      int         n  = pat.len();
      logic [2:0] np;
      if (pos < n && b == 8'(pat[pos])) np = pos + 3'd1;
      else np = (b == 8'(pat[0])) ? 3'd1 : 3'd0;
      if (np >= n) begin
         ev_found = 1'b1;
         np       = '0;
      end
      return np;
   endfunction

   function automatic void name_byte(logic [7:0] b);
      logic [7:0] u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
      for (int k = 0; k < 6; k++) begin
         if (name_len >= header_txt[k].len() || u != 8'(header_txt[k][name_len]))
            name_cand[k] = 1'b0;
      end
      if (name_len < 4'd11) name_len++;
   endfunction

   function automatic void colon_seen();
      logic hit = 1'b0;
      phase = PH_REST;
      for (int k = 0; k < 6; k++) begin
         if (!hit && name_cand[k] && header_txt[k].len() == name_len && hdr_en[k]) begin
            hit      = 1'b1;
            phase    = PH_VSKIP;
            cur_hdr  = 3'(k);
            val_cnt  = '0;
            trim_cnt = '0;
         end
      end
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic fin, input logic known);
      out_rec_type    outq [$];
      start_kind_type sk;
      logic           acc;
      if (byte_cnt < 4'd9) begin
         for (int k = 0; k < 3; k++) begin
            if (byte_cnt < prefix_txt[k].len() && b != 8'(prefix_txt[k][byte_cnt]))
               pfx_cand[k] = 1'b0;
         end
         byte_cnt++;
      end
      st_pos   = ev_step(st_pos, b, "\015\nST:");
      usn_pos  = ev_step(usn_pos, b, "\015\nUSN:");
      upnp_pos = ev_step(upnp_pos, b, "UPnP");

      case (phase)
         PH_START: begin
            if (b == ASCII_LF) begin
               phase         = PH_LSTART;
               line_nonempty = 1'b0;
            end
         end
         PH_LSTART: begin
            if (b == ASCII_LF) begin
               phase = PH_DONE;
            end else begin
               phase         = PH_NAME;
               name_cand     = 6'h3F;
               name_len      = '0;
               line_nonempty = (b != ASCII_CR);
               if (b == ASCII_COLON) colon_seen();
               else name_byte(b);
            end
         end
         PH_NAME: begin
            if (b == ASCII_LF) begin
               phase         = line_nonempty ? PH_LSTART : PH_DONE;
               line_nonempty = 1'b0;
            end else begin
               line_nonempty = 1'b1;
               if (b == ASCII_COLON) colon_seen();
               else name_byte(b);
            end
         end
         PH_VSKIP, PH_VALUE: begin
            if (b == ASCII_LF || b == ASCII_CR) begin
               outq.push_back(make_rec(REC_VALUE_END, cur_hdr, '0, trim_cnt, START_NONE, 1'b0));
               phase         = (b == ASCII_LF) ? PH_LSTART : PH_REST;
               line_nonempty = 1'b0;
            end else if (!(phase == PH_VSKIP && (b == ASCII_SP || b == ASCII_TAB))) begin
               phase = PH_VALUE;
               if (val_cnt < 10'(VALUE_CAP)) begin
                  val_cnt++;
                  if (b != ASCII_SP && b != ASCII_TAB) trim_cnt = val_cnt;
                  outq.push_back(make_rec(REC_VALUE_BYTE, cur_hdr, b, '0, START_NONE, 1'b0));
               end
            end
         end
         PH_REST: begin
            if (b == ASCII_LF) begin
               phase         = PH_LSTART;
               line_nonempty = 1'b0;
            end
         end
         default: ;
      endcase

      if (fin) begin
         if (phase == PH_VSKIP || phase == PH_VALUE)
            outq.push_back(make_rec(REC_VALUE_END, cur_hdr, '0, trim_cnt, START_NONE, 1'b0));
         sk = START_NONE;
         if (pfx_cand[0] && byte_cnt >= 4'd9) sk = START_MSEARCH;
         else if (pfx_cand[1] && byte_cnt >= 4'd9) sk = START_NOTIFY;
         else if (pfx_cand[2] && byte_cnt >= 4'd8) sk = START_HTTP;
         acc = (sk == START_MSEARCH || sk == START_NOTIFY ||
                (sk == START_HTTP && (known || ev_found)));
         outq.push_back(make_rec(REC_VERDICT, '0, '0, '0, sk, acc));
         packet_clear();
      end

      if (outq.size() != 0) outq[outq.size() - 1].last = 1'b1;
      foreach (outq[i]) records_due.push_back(outq[i]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin, input logic known);
      while (!steady && $urandom_range(99) < 21) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.data_byte     <= b;
      req.packet_end    <= fin;
      req.session_known <= known;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      parse_byte(b, fin, known);
   endtask

   task automatic send_packet(input bit known);
      foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, known);
   endtask

   task automatic push_text(input string s, input bit mix);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = 8'(s[i]);
         if (mix && c >= "A" && c <= "Z" && $urandom_range(1)) c = c + 8'd32;
         pkt_bytes.push_back(c);
      end
   endtask

   function automatic logic [7:0] value_char();
      case ($urandom_range(7))
         0: return ASCII_SP;
         1: return ASCII_TAB;
         2: return 8'(8'h80 + $urandom_range(127));
         default: return 8'($urandom_range(8'h21, 8'h7E));
      endcase
   endfunction

   function automatic logic [7:0] ws_char();
      return $urandom_range(1) ? ASCII_SP : ASCII_TAB;
   endfunction

   // mostly well-formed SSDP, with broken start lines, odd names and cut-off packets
   task automatic make_packet(output bit known);
      int sel;
      int j;
      pkt_bytes.delete();
      sel = $urandom_range(9);
      if (sel < 8) push_text(start_txt[sel % 3], sel == 7);
      else repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(3) != 0) push_text("\015\n", 1'b0);
      else pkt_bytes.push_back(ASCII_LF);
      repeat ($urandom_range(3)) begin
         sel = $urandom_range(8);
         j   = $urandom_range(5);
         if (sel < 6) begin
            push_text(header_txt[sel], 1'b1);
         end else if (sel == 6) begin
            push_text(header_txt[j].substr(0, header_txt[j].len() - 2), 1'b1);
         end else if (sel == 7) begin
            push_text(header_txt[j], 1'b1);
            push_text("X", 1'b0);
         end else begin
            repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(255)));
         end
         if ($urandom_range(9) != 0) pkt_bytes.push_back(ASCII_COLON);
         repeat ($urandom_range(2)) pkt_bytes.push_back(ws_char());
         repeat ($urandom_range(5)) pkt_bytes.push_back(value_char());
         if ($urandom_range(5) == 0) push_text("UPnP", 1'b0);
         repeat ($urandom_range(2)) pkt_bytes.push_back(ws_char());
         case ($urandom_range(3))
            0: pkt_bytes.push_back(ASCII_LF);
            1: begin
               pkt_bytes.push_back(ASCII_CR);
               pkt_bytes.push_back(value_char());
               pkt_bytes.push_back(ASCII_LF);
            end
            default: push_text("\015\n", 1'b0);
         endcase
      end
      if ($urandom_range(2) == 0) begin
         if ($urandom_range(1)) push_text("\015\n", 1'b0);
         else pkt_bytes.push_back(ASCII_LF);
         repeat ($urandom_range(3)) pkt_bytes.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(4) == 0)
         repeat ($urandom_range(pkt_bytes.size() - 1)) void'(pkt_bytes.pop_back());
      known = $urandom_range(1);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (records_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_enable(input logic [5:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      hdr_en       = v;
   endtask

   function automatic void report(string what, out_rec_type want, out_rec_type got);
      if (errors < 10) begin
         $write("%s: exp kind=%0d hdr=%0d byte=%02h len=%0d start=%0d acc=%0b last=%0b, ",
                what, want.kind, want.hdr, want.vbyte, want.vlen, want.sk, want.acc, want.last);
         $display("got kind=%0d hdr=%0d byte=%02h len=%0d start=%0d acc=%0b last=%0b",
                  got.kind, got.hdr, got.vbyte, got.vlen, got.sk, got.acc, got.last);
      end
      errors++;
   endfunction

   always @(posedge clock) begin : result_check
      out_rec_type got;
      out_rec_type want;
      rsp_take <= steady || ($urandom_range(99) >= 21);
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind  = rec_kind_type'(rsp.record_kind);
         got.hdr   = rsp.header_kind;
         got.vbyte = rsp.value_byte;
         got.vlen  = rsp.value_length;
         got.sk    = start_kind_type'(rsp.start_kind);
         got.acc   = rsp.accepted;
         got.last  = rsp.last_of_run;
         if (records_due.size() == 0) begin
            report("unexpected record", '0, got);
         end else begin
            want = records_due.pop_front();
            if (got !== want) report("mismatch", want, got);
         end
      end
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      out_rec_type v;
      bit          known;
      logic [5:0]  en_list [5];
      int          sent;
      req.valid         <= 1'b0;
      req.data_byte     <= '0;
      req.packet_end    <= 1'b0;
      req.session_known <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      hdr_en = 6'h3F;
      packet_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) begin
         pkt_bytes.delete();
         for (int c = 0; c < probes[i].text.len(); c++)
            pkt_bytes.push_back(8'(probes[i].text[c]));
         send_packet(probes[i].known);
         if (probes[i].typed) begin
            v     = records_due.pop_back();
            v.sk  = probes[i].sk;
            v.acc = probes[i].acc;
            records_due.push_back(v);
         end
      end
      drain();

      en_list = '{6'h00, 6'($urandom_range(1, 62)), 6'h15, 6'h2A, 6'h3F};
      foreach (en_list[p]) begin
         write_enable(en_list[p]);
         steady = (p == 2);
         sent   = 0;
         while (sent < PHASE_BYTES) begin
            make_packet(known);
            sent += pkt_bytes.size();
            send_packet(known);
         end
         if (p == 4) begin
            // value longer than the buffer
            pkt_bytes.delete();
            push_text("HTTP/1.1\015\nLOCATION: ", 1'b0);
            repeat (VALUE_CAP + 8) pkt_bytes.push_back(value_char());
            push_text("\015\n", 1'b0);
            send_packet(1'b0);
         end
         drain();
      end

      if (errors == 0 && records_due.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
